[src/cslj_pkg.sv]
// Package for the comment-stripping line joiner.
// Holds character constants, scan modes, result kinds and the queue entry type.
// No dependencies; used by every module of the block.
package cslj_pkg;

   // Most results one item can cause, and the default depth of the front/back queue
   localparam int MAX_RESULTS         = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CNT_W               = $clog2(MAX_RESULTS + 1);

   // Characters of interest
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_BAR     = 8'h7C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_STAR,
      MODE_HALT
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      CLS_NEWLINE,
      CLS_SLASH,
      CLS_STAR,
      CLS_FORBID,
      CLS_OTHER
   } class_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
   } result_type;

   // One queue entry: all results caused by one item, slot 0 first
   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      result_type [MAX_RESULTS-1:0]     res;
   } cmd_type;

   // Sort a byte into the classes the scanner cares about
   function automatic class_type classify(input logic [7:0] b);
      class_type cls;
      case (b) inside
         CHAR_NEWLINE: cls = CLS_NEWLINE;
         CHAR_SLASH:   cls = CLS_SLASH;
         CHAR_STAR:    cls = CLS_STAR;
         CHAR_HASH, CHAR_BAR, CHAR_EQUAL, CHAR_AMP: cls = CLS_FORBID;
         default:      cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

[src/cslj_front.sv]
// Front part of the line joiner: accepts input items, tracks the scan mode
// and builds one queue entry holding every result an item causes.
// Depends on cslj_pkg.
module cslj_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             push_valid,
   input  logic             push_ready,
   output cslj_pkg::cmd_type push_data
);
   import cslj_pkg::*;

   mode_type  mode_ff, mode_in;
   logic      sep_ff, sep_in;
   logic      emitted_ff, emitted_in;
   logic      accept;
   class_type cls;
   cmd_type   cmd;
   logic [CNT_W-1:0] n;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign cls        = classify(req_tdata);

   // Next scan state
   always_comb begin
      mode_in    = mode_ff;
      sep_in     = sep_ff;
      emitted_in = emitted_ff;
      if (mode_ff != MODE_HALT && req_tlast) begin
         mode_in    = MODE_NORMAL;
         sep_in     = 1'b0;
         emitted_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               case (cls)
                  CLS_NEWLINE: sep_in = sep_ff | emitted_ff;
                  CLS_SLASH:   mode_in = MODE_SLASH;
                  CLS_FORBID:  mode_in = MODE_HALT;
                  default: begin
                     sep_in     = 1'b0;
                     emitted_in = 1'b1;
                  end
               endcase
            end
            MODE_SLASH: begin
               case (cls)
                  CLS_SLASH: mode_in = MODE_LINE;
                  CLS_STAR:  mode_in = MODE_BLOCK;
                  default: begin
                     // the '/' is kept, then the byte is handled as normal text
                     mode_in    = MODE_NORMAL;
                     sep_in     = 1'b0;
                     emitted_in = 1'b1;
                     case (cls)
                        CLS_NEWLINE: sep_in  = 1'b1;
                        CLS_FORBID:  mode_in = MODE_HALT;
                        default:     mode_in = MODE_NORMAL;
                     endcase
                  end
               endcase
            end
            MODE_LINE: begin
               if (cls == CLS_NEWLINE) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (cls == CLS_STAR) mode_in = MODE_STAR;
            end
            MODE_STAR: begin
               if (cls == CLS_SLASH) begin
                  mode_in = MODE_NORMAL;
               end else if (cls != CLS_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Results of the current item
   always_comb begin
      cmd = '0;
      n   = '0;
      if (mode_ff != MODE_HALT && req_tlast) begin
         cmd.res[n] = '{data: CHAR_NUL, kind: KIND_END};
         n = n + 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (cls == CLS_FORBID) begin
                  cmd.res[n] = '{data: req_tdata, kind: KIND_ERROR};
                  n = n + 1'b1;
               end else if (cls == CLS_OTHER || cls == CLS_STAR) begin
                  if (sep_ff) begin
                     cmd.res[n] = '{data: CHAR_BAR, kind: KIND_DATA};
                     n = n + 1'b1;
                  end
                  cmd.res[n] = '{data: req_tdata, kind: KIND_DATA};
                  n = n + 1'b1;
               end
            end
            MODE_SLASH: begin
               if (cls != CLS_SLASH && cls != CLS_STAR) begin
                  if (sep_ff) begin
                     cmd.res[n] = '{data: CHAR_BAR, kind: KIND_DATA};
                     n = n + 1'b1;
                  end
                  cmd.res[n] = '{data: CHAR_SLASH, kind: KIND_DATA};
                  n = n + 1'b1;
                  if (cls == CLS_FORBID) begin
                     cmd.res[n] = '{data: req_tdata, kind: KIND_ERROR};
                     n = n + 1'b1;
                  end else if (cls == CLS_OTHER) begin
                     cmd.res[n] = '{data: req_tdata, kind: KIND_DATA};
                     n = n + 1'b1;
                  end
               end
            end
            default: n = '0;
         endcase
      end
      cmd.count = n;
   end

   assign push_valid = accept && (cmd.count != '0);
   assign push_data  = cmd;

   // Advance the scan state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         sep_ff     <= 1'b0;
         emitted_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         sep_ff     <= sep_in;
         emitted_ff <= emitted_in;
      end
   end

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HALT |=> mode_ff == MODE_HALT)
      else $error("front left the halted mode without reset");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast && mode_ff != MODE_HALT
      |=> mode_ff == MODE_NORMAL && !sep_ff && !emitted_ff)
      else $error("end of stream did not clear the scan state");

endmodule

[src/cslj_queue.sv]
// Short FIFO that parts the front and back of the line joiner.
// Holds whole result groups, one entry per item with results. Depends on cslj_pkg.
module cslj_queue #(
   parameter int DEPTH = cslj_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cslj_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cslj_pkg::cmd_type pop_data
);
   import cslj_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_Q = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_Q-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != CNT_Q'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_Q'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

[src/cslj_back.sv]
// Back part of the line joiner: takes result groups from the queue and
// sends them one result per cycle while the receiver is ready, through a
// registered output stage. Depends on cslj_pkg.
module cslj_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cslj_pkg::cmd_type pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import cslj_pkg::*;

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff;
   kind_type         kind_ff;
   logic             last_ff;
   logic             advance, load, last_hit;
   result_type       head;

   assign advance  = !valid_ff || rsp_tready;
   assign load     = advance && pop_valid;
   assign head     = pop_data.res[idx_ff];
   assign last_hit = (idx_ff == pop_data.count - CNT_W'(1));
   assign pop_ready = load && last_hit;

   // Step through the results of the head entry
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) valid_in = pop_valid;
      if (load) idx_in = last_hit ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.data;
         kind_ff <= head.kind;
         last_ff <= last_hit;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = 2'(kind_ff);
   assign rsp_tlast  = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> idx_ff < pop_data.count)
      else $error("result index beyond the entry's count");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == KIND_END || kind_ff == KIND_ERROR) |-> last_ff)
      else $error("end or error result not marked last");

endmodule

[src/comment_stripping_line_joiner.sv]
// Top level of the comment-stripping line joiner.
// Instantiates cslj_front, cslj_queue and cslj_back; depends on cslj_pkg.
//
// Usage:
//   req_* carries one input character per item in req_tdata; req_tlast set
//   marks the end of the stream (req_tdata then ignored).
//   rsp_* carries one result per item: rsp_tdata is the kept byte, the '|'
//   separator or the offending byte; rsp_tuser is the kind (0 data, 1 end of
//   stream, 2 forbidden character); rsp_tlast marks the last result of the
//   input item that caused it.
//   Timing: the item is written to the queue at its accepting edge and the
//   output register then loads its first result from the queue, so
//   rsp_tvalid is registered behind the queue. Throughput: one input item
//   per cycle while each item makes at most one result and the receiver
//   is ready; the output stage sends one result per cycle, so an item that
//   makes two or three results holds the back end until all are sent, and
//   the queue of QUEUE_DEPTH entries absorbs the difference.
//   Reset clears the scan state and empties the queue; no clearing pass.
//   When the receiver stalls, the output register holds its result, the
//   queue fills and then req_tready drops. After a forbidden character the
//   block swallows every item until reset.
module comment_stripping_line_joiner #(
   parameter int QUEUE_DEPTH = cslj_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast    // is_last
);
   import cslj_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    pop_valid, pop_ready;
   cmd_type pop_data;

   cslj_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cslj_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cslj_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
